// ----- hdl/vector_dot_distance_accumulator_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the vector dot and distance accumulator
// Shared concurrent check forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef VECTOR_DOT_DISTANCE_ACCUMULATOR_TOP_ASSERT_SVH
`define VECTOR_DOT_DISTANCE_ACCUMULATOR_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VDDA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vdda: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define VDDA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vdda: next-cycle check failed");

`endif

// ----- hdl/vdda_pkg.sv -----
// ----------------------------------------------------------------------------
// Vector dot and distance accumulator package
// Shared widths, constants, operation codes and controller interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vdda_pkg;

  // Default element width; elements are signed Q16.16.
  localparam int ELEMENT_WIDTH = 32;
  localparam int FIELD_W       = 32;
  localparam int FRAC_BITS     = 16;

  // Result is signed Q32.32.
  localparam int RES_W   = 64;
  localparam int Q_SHIFT = 32;

  // Square root unit: radicand is the sum scaled by 2^32.
  localparam int RAD_W  = RES_W + Q_SHIFT;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int CNT_W  = $clog2(ROOT_W);

  // Largest difference whose square still fits in a positive sum.
  localparam logic [RES_W-1:0] SQ_LIMIT = 64'd3037000499;
  localparam logic [RES_W-1:0] SUM_MAX  = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic [RES_W-1:0] SUM_MIN  = {1'b1, {(RES_W-1){1'b0}}};

  // Reduction selected by the operation register.
  typedef enum logic [1:0] {
    OP_DOT,
    OP_NORM,
    OP_EUCLID,
    OP_MANHATTAN
  } vdda_op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic acc_en;
    logic root_start;
    logic root_step;
    logic out_load;
    logic sel_root;
  } vdda_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic s3_root;
  } vdda_status_t;

endpackage

// ----- hdl/vdda_in_if.sv -----
// ----------------------------------------------------------------------------
// Input channel interface
// Carries one pair of vector elements and the last-pair mark per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface vdda_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [vdda_pkg::FIELD_W-1:0]   first_element;
  logic signed [vdda_pkg::FIELD_W-1:0]   second_element;
  logic                                  last_element;

  modport source (
    output valid, first_element, second_element, last_element,
    input  ready
  );

  modport sink (
    input  valid, first_element, second_element, last_element,
    output ready
  );
endinterface

// ----- hdl/vdda_out_if.sv -----
// ----------------------------------------------------------------------------
// Output channel interface
// Carries one reduction result and its overflow flag per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface vdda_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [vdda_pkg::RES_W-1:0]   result_value;
  logic                                overflow;

  modport source (
    output valid, result_value, overflow,
    input  ready
  );

  modport sink (
    input  valid, result_value, overflow,
    output ready
  );
endinterface

// ----- hdl/vdda_sqrt.sv -----
// ----------------------------------------------------------------------------
// Iterative square root
// Digit-by-digit root of the Q32.32 sum, one result bit per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vdda_sqrt (
  input  logic                                clk_i,
  input  logic                                start_i,
  input  logic                                step_i,
  input  logic signed [vdda_pkg::RES_W-1:0]   radicand_i,
  output logic [vdda_pkg::ROOT_W-1:0]         root_o
);

  localparam int RadW  = vdda_pkg::RAD_W;
  localparam int RootW = vdda_pkg::ROOT_W;
  localparam int RemW  = vdda_pkg::REM_W;
  localparam int ShW   = RemW + 2;

  logic [RadW-1:0]  rad_q;
  logic [RemW-1:0]  rem_q;
  logic [RootW-1:0] root_q;

  logic [ShW-1:0]   rem_sh;
  logic [ShW-1:0]   trial;
  logic [ShW-1:0]   diff;
  logic             fits;
  logic [vdda_pkg::RES_W-1:0] sum_pos;

  // A negative sum roots to zero.
  assign sum_pos = (radicand_i > 0) ? radicand_i : '0;

  // Bring down the next two radicand bits and try appending a one.
  assign rem_sh = {rem_q, rad_q[RadW-1 -: 2]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign diff   = rem_sh - trial;
  assign fits   = (rem_sh >= trial);

  // Radicand, partial remainder and root registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= {sum_pos, {vdda_pkg::Q_SHIFT{1'b0}}};
      rem_q  <= '0;
      root_q <= '0;
    end else if (step_i) begin
      rad_q  <= {rad_q[RadW-3:0], 2'b00};
      rem_q  <= fits ? diff[RemW-1:0] : rem_sh[RemW-1:0];
      root_q <= {root_q[RootW-2:0], fits};
    end
  end

  assign root_o = root_q;

endmodule

// ----- hdl/vdda_ctrl.sv -----
// ----------------------------------------------------------------------------
// Accumulator controller
// Tracks words through the datapath and sequences the finishing steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "vector_dot_distance_accumulator_top_assert.svh"

module vdda_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_last_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  vdda_pkg::vdda_status_t status_i,
  output vdda_pkg::vdda_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_RUN,
    ST_DRAIN,
    ST_FINISH,
    ST_ROOT,
    ST_HOLD
  } state_e;

  state_e                     state_q;
  logic                       in_ready_q;
  logic                       out_valid_q;
  logic                       root_q;
  logic [vdda_pkg::CNT_W-1:0] cnt_q;
  logic                       v1_q, v2_q, v3_q;
  logic                       l1_q, l2_q, l3_q;

  logic accept;
  logic out_load;

  assign accept   = in_valid_i && in_ready_q;
  assign out_load = (state_q == ST_HOLD) && (!out_valid_q || out_ready_i);

  // Command decode.
  always_comb begin
    cmd_o            = '0;
    cmd_o.accept     = accept;
    cmd_o.acc_en     = v3_q;
    cmd_o.root_start = (state_q == ST_FINISH) && root_q;
    cmd_o.root_step  = (state_q == ST_ROOT);
    cmd_o.out_load   = out_load;
    cmd_o.sel_root   = root_q;
  end

  // State, word tracking and handshake registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
      root_q      <= 1'b0;
      cnt_q       <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      l1_q        <= 1'b0;
      l2_q        <= 1'b0;
      l3_q        <= 1'b0;
    end else begin
      v1_q <= accept;
      l1_q <= accept && in_last_i;
      v2_q <= v1_q;
      l2_q <= l1_q;
      v3_q <= v2_q;
      l3_q <= l2_q;

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_RUN: begin
          if (accept && in_last_i) begin
            in_ready_q <= 1'b0;
            state_q    <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (v3_q && l3_q) begin
            root_q  <= status_i.s3_root;
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          cnt_q   <= vdda_pkg::CNT_W'(vdda_pkg::ROOT_W - 1);
          state_q <= root_q ? ST_ROOT : ST_HOLD;
        end
        ST_ROOT: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_q <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_load) begin
            in_ready_q <= 1'b1;
            state_q    <= ST_RUN;
          end
        end
        default: begin
          state_q <= ST_RUN;
        end
      endcase
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

  // A last word closes the input until its result is handed off.
  `VDDA_ASSERT_NEXT(a_last_blocks_input, accept && in_last_i, !in_ready_q)
  // The last word reaching the accumulator starts the finishing steps.
  `VDDA_ASSERT_NEXT(a_last_finishes, v3_q && l3_q, state_q == ST_FINISH)
  // The root steps end in the hold state once the step counter reaches zero.
  `VDDA_ASSERT_NEXT(a_root_ends, (state_q == ST_ROOT) && (cnt_q == '0), state_q == ST_HOLD)
  // No word enters while a result is still being finished.
  `VDDA_ASSERT_NOW(a_closed_while_busy, state_q != ST_RUN, !in_ready_q)

endmodule

// ----- hdl/vdda_datapath.sv -----
// ----------------------------------------------------------------------------
// Accumulator datapath
// Capture, operand and multiplier stages, saturating sum and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vdda_datapath #(
  parameter int ELEMENT_WIDTH = vdda_pkg::ELEMENT_WIDTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_data_i,
  input  logic signed [vdda_pkg::FIELD_W-1:0] first_element_i,
  input  logic signed [vdda_pkg::FIELD_W-1:0] second_element_i,
  input  vdda_pkg::vdda_cmd_t                 cmd_i,
  output vdda_pkg::vdda_status_t              status_o,
  output logic signed [vdda_pkg::RES_W-1:0]   result_value_o,
  output logic                                overflow_o
);

  localparam int Ew   = ELEMENT_WIDTH;
  localparam int Dw   = Ew + 1;
  localparam int Pw   = 2 * Dw;
  localparam int ResW = vdda_pkg::RES_W;

  vdda_pkg::vdda_op_e op_q;

  // Stage 1: captured elements.
  logic signed [Ew-1:0] a1_q, b1_q;
  vdda_pkg::vdda_op_e   op1_q;

  // Stage 2: multiplier operands and difference terms.
  logic signed [Dw-1:0] mop_a_q, mop_b_q;
  logic [ResW-1:0]      abs_term_q;
  logic                 sq_sat2_q;
  vdda_pkg::vdda_op_e   op2_q;

  // Stage 3: term to add.
  logic signed [ResW-1:0] term_q;
  logic                   sat3_q;
  vdda_pkg::vdda_op_e     op3_q;

  // Accumulator and result.
  logic signed [ResW-1:0] acc_q;
  logic                   flag_q;
  logic signed [ResW-1:0] result_q;
  logic                   ovf_q;

  logic signed [Dw-1:0]   diff;
  logic signed [Dw-1:0]   diff_neg;
  logic [Ew-1:0]          abs_diff;
  logic signed [Pw-1:0]   prod;
  logic signed [ResW:0]   sum_wide;
  logic                   sum_ovf;
  logic signed [ResW-1:0] sum_sat;
  logic [vdda_pkg::ROOT_W-1:0] root;

  // Operation register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= vdda_pkg::OP_DOT;
    end else if (cfg_we_i) begin
      op_q <= vdda_pkg::vdda_op_e'(cfg_data_i);
    end
  end

  // Stage 1 capture of the low element bits.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      a1_q  <= $signed(first_element_i[Ew-1:0]);
      b1_q  <= $signed(second_element_i[Ew-1:0]);
      op1_q <= op_q;
    end
  end

  // Absolute difference; it always fits the element width unsigned.
  assign diff     = Dw'(a1_q) - Dw'(b1_q);
  assign diff_neg = -diff;
  assign abs_diff = diff[Dw-1] ? diff_neg[Ew-1:0] : diff[Ew-1:0];

  // Stage 2: pick multiplier operands.
  always_ff @(posedge clk_i) begin
    op2_q      <= op1_q;
    abs_term_q <= ResW'({abs_diff, {vdda_pkg::FRAC_BITS{1'b0}}});
    sq_sat2_q  <= (ResW'(abs_diff) > vdda_pkg::SQ_LIMIT);
    case (op1_q)
      vdda_pkg::OP_DOT: begin
        mop_a_q <= Dw'(a1_q);
        mop_b_q <= Dw'(b1_q);
      end
      vdda_pkg::OP_NORM: begin
        mop_a_q <= Dw'(a1_q);
        mop_b_q <= Dw'(a1_q);
      end
      default: begin
        mop_a_q <= $signed({1'b0, abs_diff});
        mop_b_q <= $signed({1'b0, abs_diff});
      end
    endcase
  end

  assign prod = mop_a_q * mop_b_q;

  // Stage 3: form the term, clamping an oversized square.
  always_ff @(posedge clk_i) begin
    op3_q  <= op2_q;
    sat3_q <= (op2_q == vdda_pkg::OP_EUCLID) && sq_sat2_q;
    case (op2_q)
      vdda_pkg::OP_MANHATTAN: term_q <= $signed(abs_term_q);
      vdda_pkg::OP_EUCLID: term_q <= sq_sat2_q ? $signed(vdda_pkg::SUM_MAX) : ResW'(prod);
      default: term_q <= ResW'(prod);
    endcase
  end

  assign status_o.s3_root = (op3_q == vdda_pkg::OP_NORM) || (op3_q == vdda_pkg::OP_EUCLID);

  // Saturating add of the term to the running sum.
  assign sum_wide = {acc_q[ResW-1], acc_q} + {term_q[ResW-1], term_q};
  assign sum_ovf  = (sum_wide[ResW] != sum_wide[ResW-1]);
  assign sum_sat  = sum_ovf ? (term_q[ResW-1] ? $signed(vdda_pkg::SUM_MIN)
                                              : $signed(vdda_pkg::SUM_MAX))
                            : sum_wide[ResW-1:0];

  // Running sum and overflow flag; cleared when the result leaves.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      flag_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      acc_q  <= '0;
      flag_q <= 1'b0;
    end else if (cmd_i.acc_en) begin
      acc_q  <= sum_sat;
      flag_q <= flag_q || sum_ovf || sat3_q;
    end
  end

  vdda_sqrt u_sqrt (
    .clk_i      (clk_i),
    .start_i    (cmd_i.root_start),
    .step_i     (cmd_i.root_step),
    .radicand_i (acc_q),
    .root_o     (root)
  );

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      result_q <= cmd_i.sel_root ? $signed(ResW'(root)) : acc_q;
      ovf_q    <= flag_q;
    end
  end

  assign result_value_o = result_q;
  assign overflow_o     = ovf_q;

endmodule

// ----- hdl/vector_dot_distance_accumulator_top.sv -----
// Vector dot product, norm and distance accumulator.
// The input channel takes one word per element pair: two signed Q16.16
// elements and a mark on the last pair. While the input is open, non-last
// words stream in at one per cycle, each folded into a saturating Q32.32
// running sum via capture, operand and multiplier stages and accumulator.
// The last word of a vector closes the input until its result is handed to
// the output register. For the norm and the Euclidean distance the result is
// the 48-bit square root of the sum, found bit-serially, one bit per cycle.
// The output channel carries the result and its overflow flag; a stalled
// receiver holds the result, and the next vector may stream in meanwhile,
// its own result waiting until the register is free.
// The user must write the operation register only while the block is idle,
// which the block itself does not enforce. Reset clears the sum, the flag
// and the operation (dot product) and opens the input.
// ----------------------------------------------------------------------------
// Vector dot and distance accumulator top level
// Joins the controller and the datapath to the two channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vector_dot_distance_accumulator_top #(
  parameter int ELEMENT_WIDTH = vdda_pkg::ELEMENT_WIDTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_data_i,
  vdda_in_if.sink     in_if,
  vdda_out_if.source  out_if
);

  vdda_pkg::vdda_cmd_t    cmd;
  vdda_pkg::vdda_status_t status;

  // Sequencing.
  vdda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_last_i   (in_if.last_element),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Arithmetic.
  vdda_datapath #(
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .first_element_i  (in_if.first_element),
    .second_element_i (in_if.second_element),
    .cmd_i            (cmd),
    .status_o         (status),
    .result_value_o   (out_if.result_value),
    .overflow_o       (out_if.overflow)
  );

endmodule
